>>> rtl/core/pra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pra_pkg: shared types and constants for the page run allocator
// Page tag type, opcodes, field widths and the neighbour-aware tag choice.
// ----------------------------------------------------------------------------
package pra_pkg;

	// field widths of the request and result words
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned PAGE_W  = 8;

	// 2-bit page tag, zero means the page is free
	typedef logic [1:0] tag_t;

	localparam tag_t TAG_FREE = 2'd0;
	localparam tag_t TAG_ONE  = 2'd1;
	localparam tag_t TAG_TWO  = 2'd2;
	localparam tag_t TAG_THREE = 2'd3;

	// request opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// pick a tag that differs from both the previous and the next page
	function automatic tag_t pick_tag(input tag_t prev, input tag_t next);
		tag_t res;
		case (prev)
			TAG_FREE:  res = (next == TAG_ONE) ? TAG_TWO : TAG_ONE;
			TAG_ONE:   res = (next == TAG_TWO) ? TAG_THREE : TAG_TWO;
			TAG_TWO:   res = (next == TAG_ONE) ? TAG_THREE : TAG_ONE;
			default:   res = (next == TAG_ONE) ? TAG_TWO : TAG_ONE;
		endcase
		return res;
	endfunction

endpackage

>>> rtl/core/pra_tag_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pra_tag_ram: page tag memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pra_tag_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  pra_pkg::tag_t   wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output pra_pkg::tag_t   rdata
);
	import pra_pkg::*;

	tag_t mem_q [DEPTH];
	tag_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/page_run_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_run_allocator_unit: first-fit page run allocator
// Tags runs of free pages in a page map and frees runs by start page.
// ----------------------------------------------------------------------------
// After reset the block clears the page map, one page a cycle, while it
// takes no word. It then handles one word at a time. An allocate walks the
// single read port of the tag memory from page 0, one page a cycle, until
// the first fitting run ends, then writes the run one page a cycle. An
// allocate that finds no run, one that asks for more pages than the map
// holds, and a free beyond the map answer with success low. A free reads
// and clears its run one page a cycle. A finished result waits in an output
// register and does not hold back the next word; while that register still
// holds an untaken result, the next result waits and the block takes no
// word.
// ----------------------------------------------------------------------------
module page_run_allocator_unit #(
	parameter int unsigned PAGES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [pra_pkg::COUNT_W-1:0]   page_count,
	input  logic [pra_pkg::PAGE_W-1:0]    free_page,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          success,
	output logic [pra_pkg::PAGE_W-1:0]    first_page,
	output pra_pkg::tag_t                 tag
);
	import pra_pkg::*;

	localparam int unsigned IW = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int unsigned CW = $clog2(PAGES + 1);
	localparam logic [IW-1:0] LAST_IDX   = IW'(PAGES - 1);
	localparam logic [CW-1:0] LAST_CNT   = CW'(PAGES - 1);
	localparam logic [CW-1:0] PAGES_CNT  = CW'(PAGES);

	// sequencer states
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_NEXT  = 3'd3;
	localparam logic [2:0] S_FILL  = 3'd4;
	localparam logic [2:0] S_FREE  = 3'd5;
	localparam logic [2:0] S_RESP  = 3'd6;

	logic [2:0]           state_q;
	logic [CW-1:0]        addr_q;
	logic [IW-1:0]        chk_q;
	logic                 chk_vld_q;
	logic [COUNT_W-1:0]   run_q;
	logic [COUNT_W-1:0]   want_q;
	tag_t                 prev_q;
	logic [IW-1:0]        first_q;
	logic [IW-1:0]        end_q;
	logic [IW-1:0]        fill_q;
	tag_t                 new_tag_q;
	tag_t                 free_tag_q;
	logic                 free_first_q;
	logic                 res_ok_q;
	logic [PAGE_W-1:0]    res_page_q;
	tag_t                 res_tag_q;
	logic                 out_valid_q;
	logic                 success_q;
	logic [PAGE_W-1:0]    first_page_q;
	tag_t                 tag_q;

	logic                 ram_we;
	logic [IW-1:0]        ram_waddr;
	tag_t                 ram_wdata;
	logic                 ram_re;
	tag_t                 ram_rdata;
	logic [COUNT_W-1:0]   want_in;
	logic [COUNT_W-1:0]   run_inc;
	logic                 fit;
	tag_t                 next_tag;
	tag_t                 cur_free_tag;
	logic                 free_match;
	logic                 resp_load;

	// tag memory
	pra_tag_ram #(
		.DEPTH (PAGES),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	// request decode and scan compare
	assign want_in      = (page_count == '0) ? COUNT_W'(1) : page_count;
	assign run_inc      = run_q + COUNT_W'(1);
	assign fit          = (ram_rdata == TAG_FREE) && (run_inc >= want_q);
	assign next_tag     = (end_q == LAST_IDX) ? TAG_FREE : ram_rdata;
	assign cur_free_tag = free_first_q ? ram_rdata : free_tag_q;
	assign free_match   = free_first_q || (ram_rdata == free_tag_q);

	// result moves to the output register when it is empty or being taken
	assign resp_load = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	// read issue while walking the map
	assign ram_re = ((state_q == S_SCAN) || (state_q == S_FREE)) && (addr_q < PAGES_CNT);

	// write port select
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q[IW-1:0];
		ram_wdata = TAG_FREE;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = fill_q;
				ram_wdata = new_tag_q;
			end
			S_FREE: begin
				ram_we    = chk_vld_q && free_match;
				ram_waddr = chk_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			addr_q       <= '0;
			chk_vld_q    <= 1'b0;
			free_first_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			chk_vld_q <= ram_re;
			chk_q     <= addr_q[IW-1:0];
			if (ram_re) begin
				addr_q <= addr_q + CW'(1);
			end
			// output register: load a result or drop a taken word
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				// clearing pass after reset
				S_CLEAR: begin
					if (addr_q == LAST_CNT) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + CW'(1);
					end
				end
				// take a request word
				S_IDLE: begin
					if (in_valid) begin
						if (opcode == OP_ALLOC) begin
							want_q <= want_in;
							run_q  <= '0;
							prev_q <= TAG_FREE;
							addr_q <= '0;
							if (32'(want_in) > PAGES) begin
								res_ok_q   <= 1'b0;
								res_page_q <= '0;
								res_tag_q  <= TAG_FREE;
								state_q    <= S_RESP;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							res_page_q   <= free_page;
							free_first_q <= 1'b1;
							addr_q       <= CW'(free_page);
							if (32'(free_page) >= PAGES) begin
								res_ok_q  <= 1'b0;
								res_tag_q <= TAG_FREE;
								state_q   <= S_RESP;
							end else begin
								state_q <= S_FREE;
							end
						end
					end
				end
				// first-fit scan, one page a cycle
				S_SCAN: begin
					if (chk_vld_q) begin
						if (fit) begin
							first_q <= chk_q - IW'(run_q);
							end_q   <= chk_q;
							state_q <= S_NEXT;
						end else if (chk_q == LAST_IDX) begin
							res_ok_q   <= 1'b0;
							res_page_q <= '0;
							res_tag_q  <= TAG_FREE;
							state_q    <= S_RESP;
						end else if (ram_rdata == TAG_FREE) begin
							run_q <= run_inc;
						end else begin
							run_q  <= '0;
							prev_q <= ram_rdata;
						end
					end
				end
				// next page tag is in, choose the run tag
				S_NEXT: begin
					new_tag_q <= pick_tag(prev_q, next_tag);
					fill_q    <= first_q;
					state_q   <= S_FILL;
				end
				// write the run tag one page a cycle
				S_FILL: begin
					if (fill_q == end_q) begin
						res_ok_q   <= 1'b1;
						res_page_q <= PAGE_W'(first_q);
						res_tag_q  <= new_tag_q;
						state_q    <= S_RESP;
					end else begin
						fill_q <= fill_q + IW'(1);
					end
				end
				// walk and clear the run that shares the start tag
				S_FREE: begin
					if (chk_vld_q) begin
						free_first_q <= 1'b0;
						if (free_first_q) begin
							free_tag_q <= ram_rdata;
						end
						if (!free_match || (chk_q == LAST_IDX)) begin
							res_ok_q  <= 1'b1;
							res_tag_q <= cur_free_tag;
							state_q   <= S_RESP;
						end
					end
				end
				// hand the result to the output register
				S_RESP: begin
					if (resp_load) begin
						success_q    <= res_ok_q;
						first_page_q <= res_page_q;
						tag_q        <= res_tag_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ports
	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign success    = success_q;
	assign first_page = first_page_q;
	assign tag        = tag_q;

endmodule
